FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared field widths, opcodes and character codes for the text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;

  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_ATTR     = 8'h0F;

endpackage

FILE: hdl/tcw_cmd_if.sv
// ----------------------------------------------------------------------------
// tcw_cmd_if
// Command channel: opcode, character and cell address with valid/ready.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::OPCODE_W-1:0]  opcode;
  logic [tcw_pkg::CHAR_W-1:0]    char_code;
  logic [tcw_pkg::ADDR_W-1:0]    cell_address;

  modport source (output valid, opcode, char_code, cell_address, input ready);
  modport sink   (input valid, opcode, char_code, cell_address, output ready);
endinterface

FILE: hdl/tcw_rsp_if.sv
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel: cursor position and cell data with valid/ready.
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::POS_W-1:0]   cursor_position;
  logic [tcw_pkg::CELL_W-1:0]  cell_data;

  modport source (output valid, cursor_position, cell_data, input ready);
  modport sink   (input valid, cursor_position, cell_data, output ready);
endinterface

FILE: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console: screen cell memory, cursor tracking, scroll, clear and read.
// ----------------------------------------------------------------------------
// Put, read and unused opcodes: the command transaction moves to S_RESP,
//   which registers the response once the output register is free; no
//   new command is taken until then. Put that scrolls: a copy sweep
//   through the one memory port pair. Clear: one cell written a cycle.
// Reset: a clearing pass fills the screen with 0x0F20; cmd.ready stays
//   low until it ends. Attribute writes are taken throughout.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                       clk,
  input  logic                       rst,
  tcw_cmd_if.sink                    cmd,
  tcw_rsp_if.source                  rsp,
  input  logic                       attr_we,
  input  logic [tcw_pkg::CHAR_W-1:0] attr_wdata
);
  import tcw_pkg::*;

  localparam int CELL_COUNT    = ROWS * COLUMNS;
  localparam int AW            = $clog2(CELL_COUNT);
  localparam int SW            = $clog2(CELL_COUNT + 1);
  localparam int RW            = $clog2(ROWS);
  localparam int CW            = $clog2(COLUMNS);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_CLEAR, S_SCROLL, S_RESP} state_t;

  state_t            state;
  logic [SW-1:0]     sweep;
  logic [RW-1:0]     row;
  logic [CW-1:0]     col;
  logic [AW-1:0]     pos;
  logic [CHAR_W-1:0] attr;
  logic              read_hit;
  logic              rsp_valid;
  logic [POS_W-1:0]  rsp_pos;
  logic [CELL_W-1:0] rsp_data;

  // memory ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // cursor arithmetic
  logic              accept;
  logic [CW:0]       col_inc;
  logic              col_wrap;
  logic              row_last;
  logic [AW-1:0]     pos_inc;
  logic [AW-1:0]     pos_dec;
  logic [AW:0]       pos_nl;
  logic [31:0]       addr_wide;
  logic              addr_in_range;
  logic [31:0]       pos_wide;
  logic [SW-1:0]     sweep_m1;
  logic [SW-1:0]     sweep_src;
  logic [CELL_W-1:0] blank;

  assign accept        = cmd.valid && (state == S_IDLE);
  assign col_inc       = {1'b0, col} + 1'b1;
  assign col_wrap      = (col_inc == (CW + 1)'(COLUMNS));
  assign row_last      = (row == RW'(ROWS - 1));
  assign pos_inc       = pos + 1'b1;
  assign pos_dec       = (pos == '0) ? '0 : pos - 1'b1;
  assign pos_nl        = {1'b0, pos} - (AW + 1)'(col) + (AW + 1)'(COLUMNS);
  assign addr_wide     = 32'(cmd.cell_address);
  assign addr_in_range = (addr_wide < 32'(CELL_COUNT));
  assign pos_wide      = 32'(pos);
  assign sweep_m1      = sweep - 1'b1;
  assign sweep_src     = sweep + SW'(COLUMNS);
  assign blank         = {attr, CHAR_BLANK};

  assign cmd.ready           = (state == S_IDLE);
  assign rsp.valid           = rsp_valid;
  assign rsp.cursor_position = rsp_pos;
  assign rsp.cell_data       = rsp_data;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = addr_wide[AW-1:0];
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep[AW-1:0];
        mem_wdata = {RESET_ATTR, CHAR_BLANK};
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep[AW-1:0];
      end
      S_IDLE: begin
        if (accept && cmd.opcode == OP_PUT) begin
          if (cmd.char_code == CHAR_BACKSPACE) begin
            mem_we    = 1'b1;
            mem_waddr = pos_dec;
          end else if (cmd.char_code != CHAR_NEWLINE) begin
            mem_we    = 1'b1;
            mem_wdata = {attr, cmd.char_code};
          end
        end
        mem_re = accept && (cmd.opcode == OP_READ) && addr_in_range;
      end
      S_SCROLL: begin
        // read one row below, write it back in the next cycle; bottom row gets blanks
        mem_re    = (sweep < SW'(LAST_ROW_BASE));
        mem_raddr = sweep_src[AW-1:0];
        mem_we    = (sweep != '0);
        mem_waddr = sweep_m1[AW-1:0];
        mem_wdata = (sweep_m1 < SW'(LAST_ROW_BASE)) ? mem_rdata : blank;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  tcw_screen_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      row       <= '0;
      col       <= '0;
      pos       <= '0;
      attr      <= RESET_ATTR;
      rsp_valid <= 1'b0;
    end else begin
      if (attr_we) begin
        attr <= attr_wdata;
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == SW'(CELL_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            read_hit <= 1'b0;
            state    <= S_RESP;
            unique case (cmd.opcode)
              OP_PUT: begin
                if (cmd.char_code == CHAR_NEWLINE) begin
                  col <= '0;
                  if (row_last) begin
                    pos   <= AW'(LAST_ROW_BASE);
                    sweep <= '0;
                    state <= S_SCROLL;
                  end else begin
                    row <= row + 1'b1;
                    pos <= pos_nl[AW-1:0];
                  end
                end else if (cmd.char_code == CHAR_BACKSPACE) begin
                  pos <= pos_dec;
                  if (col != '0) begin
                    col <= col - 1'b1;
                  end else if (row != '0) begin
                    row <= row - 1'b1;
                    col <= CW'(COLUMNS - 1);
                  end
                end else if (col_wrap) begin
                  col <= '0;
                  if (row_last) begin
                    pos   <= AW'(LAST_ROW_BASE);
                    sweep <= '0;
                    state <= S_SCROLL;
                  end else begin
                    row <= row + 1'b1;
                    pos <= pos_inc;
                  end
                end else begin
                  col <= col_inc[CW-1:0];
                  pos <= pos_inc;
                end
              end
              OP_CLEAR: begin
                row   <= '0;
                col   <= '0;
                pos   <= '0;
                sweep <= '0;
                state <= S_CLEAR;
              end
              OP_READ: begin
                read_hit <= addr_in_range;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == SW'(CELL_COUNT - 1)) begin
            state <= S_RESP;
          end
        end
        S_SCROLL: begin
          sweep <= sweep + 1'b1;
          if (sweep == SW'(CELL_COUNT)) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          // hold until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_pos   <= pos_wide[POS_W-1:0];
            rsp_data  <= read_hit ? mem_rdata : '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [tcw_pkg::POS_W-1:0]  rsp_cursor_position,
  input logic [tcw_pkg::CELL_W-1:0] rsp_cell_data
);
  import tcw_pkg::*;

  // reset starts the clearing pass: nothing taken, nothing offered
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !cmd_ready && !rsp_valid)
    else $error("command ready or response valid right after reset");

  // one item in flight: ready drops after each command transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second command taken while one is in work");

  // a response never appears in the cycle right after a command transaction
  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && !rsp_valid |=> !rsp_valid)
    else $error("response offered one cycle after its command");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_cursor_position) && $stable(rsp_cell_data))
    else $error("stalled response dropped or changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk                 (clk),
  .rst                 (rst),
  .cmd_valid           (cmd.valid),
  .cmd_ready           (cmd.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_cursor_position (rsp.cursor_position),
  .rsp_cell_data       (rsp.cell_data)
);

FILE: sim/text_console_writer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_test
// Drives put, clear, read and unused commands into the console. A local
// screen and cursor model predicts every response, and each response is
// checked field by field. The text attribute changes between phases, and
// both channels stall at random outside one steady phase.
// ----------------------------------------------------------------------------
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = ROWS * COLUMNS;
  localparam int IDLE_PCT   = 27;
  localparam int PHASES     = 6;
  localparam int PHASE_CMDS = 325;
  localparam int QUIET_MAX  = 20000;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [ADDR_W-1:0]   cell_address;
  } console_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
  } console_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic attr_we;
  logic [CHAR_W-1:0] attr_wdata;

  tcw_cmd_if cmd ();
  tcw_rsp_if rsp ();

  text_console_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rsp        (rsp),
    .attr_we    (attr_we),
    .attr_wdata (attr_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Screen model
  logic [CELL_W-1:0] screen [CELLS];
  int unsigned cursor_row;
  int unsigned cursor_col;
  logic [CHAR_W-1:0] text_attr;

  console_cmd_t queued_cmds [$];
  console_rsp_t predicted_rsps [$];
  console_cmd_t next_cmd;
  console_rsp_t want_rsp;
  logic steady = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  function automatic void reset_console();
    for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, CHAR_BLANK};
    cursor_row = 0;
    cursor_col = 0;
    text_attr  = RESET_ATTR;
  endfunction

  function automatic void write_char(logic [CHAR_W-1:0] ch);
    if (ch == CHAR_NEWLINE) begin
      cursor_col = 0;
      cursor_row++;
    end else if (ch == CHAR_BACKSPACE) begin
      if (cursor_col > 0) begin
        cursor_col--;
      end else if (cursor_row > 0) begin
        cursor_row--;
        cursor_col = COLUMNS - 1;
      end
      screen[cursor_row * COLUMNS + cursor_col] = {text_attr, CHAR_BLANK};
    end else begin
      screen[cursor_row * COLUMNS + cursor_col] = {text_attr, ch};
      cursor_col++;
    end
    if (cursor_col >= COLUMNS) begin
      cursor_col = 0;
      cursor_row++;
    end
    // scroll up one row past the bottom
    if (cursor_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int x = 0; x < COLUMNS; x++)
        screen[(ROWS - 1) * COLUMNS + x] = {text_attr, CHAR_BLANK};
      cursor_row = ROWS - 1;
    end
  endfunction

  function automatic console_rsp_t apply_console_cmd(console_cmd_t c);
    console_rsp_t r;
    int unsigned pos;
    r.cell_data = '0;
    case (c.opcode)
      OP_PUT: begin
        write_char(c.char_code);
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = {text_attr, CHAR_BLANK};
        cursor_row = 0;
        cursor_col = 0;
      end
      OP_READ: begin
        if (c.cell_address < CELLS) r.cell_data = screen[c.cell_address];
      end
      default: ;
    endcase
    pos = cursor_row * COLUMNS + cursor_col;
    r.cursor_position = pos[POS_W-1:0];
    return r;
  endfunction

  function automatic console_cmd_t random_console_cmd();
    console_cmd_t c;
    int unsigned r;
    int unsigned a;
    r = $urandom_range(999);
    a = $urandom_range(99);
    c.opcode       = OP_PUT;
    c.char_code    = CHAR_W'($urandom_range(255));
    c.cell_address = ADDR_W'($urandom_range(2 ** ADDR_W - 1));
    if (r < 520) begin
      c.opcode = OP_PUT;
    end else if (r < 600) begin
      c.char_code = CHAR_NEWLINE;
    end else if (r < 680) begin
      c.char_code = CHAR_BACKSPACE;
    end else if (r < 940) begin
      c.opcode = OP_READ;
      // bias reads toward the rows where text sits after scrolling
      if (a < 40) c.cell_address = ADDR_W'($urandom_range(CELLS - 1));
      else if (a < 80)
        c.cell_address = ADDR_W'($urandom_range(CELLS - 1, CELLS - 5 * COLUMNS));
      else if (a < 90) c.cell_address = ADDR_W'($urandom_range(2 * COLUMNS - 1));
      else c.cell_address = ADDR_W'($urandom_range(2 ** ADDR_W - 1, CELLS));
    end else if (r < 945) begin
      c.opcode = OP_CLEAR;
    end else begin
      c.opcode = OP_UNUSED;
    end
    return c;
  endfunction

  task automatic push_cmd(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                          logic [ADDR_W-1:0] addr);
    queued_cmds.push_back('{op, ch, addr});
  endtask

  task automatic drain_console();
    while (queued_cmds.size() != 0 || cmd.valid || predicted_rsps.size() != 0)
      @(posedge clk);
    // a scroll or clear ends before its response; let the console idle before the next phase
    repeat (8) @(posedge clk);
  endtask

  // Command driver: predict on each accepted transaction, then present the next one
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid        <= 1'b0;
      cmd.opcode       <= OP_PUT;
      cmd.char_code    <= '0;
      cmd.cell_address <= '0;
    end else begin
      if (cmd.valid && cmd.ready)
        predicted_rsps.push_back(
          apply_console_cmd('{cmd.opcode, cmd.char_code, cmd.cell_address}));
      if (!cmd.valid || cmd.ready) begin
        if (queued_cmds.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          next_cmd = queued_cmds.pop_front();
          cmd.valid        <= 1'b1;
          cmd.opcode       <= next_cmd.opcode;
          cmd.char_code    <= next_cmd.char_code;
          cmd.cell_address <= next_cmd.cell_address;
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (predicted_rsps.size() == 0) begin
          $display("%0t: response with none pending: pos %0d data %h", $time,
                   rsp.cursor_position, rsp.cell_data);
          errors++;
        end else begin
          want_rsp = predicted_rsps.pop_front();
          if (rsp.cursor_position !== want_rsp.cursor_position) begin
            $display("%0t: cursor_position expected %0d actual %0d", $time,
                     want_rsp.cursor_position, rsp.cursor_position);
            errors++;
          end
          if (rsp.cell_data !== want_rsp.cell_data) begin
            $display("%0t: cell_data expected %h actual %h", $time,
                     want_rsp.cell_data, rsp.cell_data);
            errors++;
          end
        end
      end
      rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_MAX);
      $display("text_console_writer_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CHAR_W-1:0] phase_attr [PHASES];
    phase_attr = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'h00};
    phase_attr[4] = CHAR_W'($urandom_range(255));
    phase_attr[5] = CHAR_W'($urandom_range(255));
    attr_we          = 1'b0;
    attr_wdata       = '0;
    reset_console();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed pass under the reset attribute
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd1999);
    push_cmd(OP_READ, 8'hFF, 11'd2000);
    push_cmd(OP_READ, 8'hFF, 11'h7FF);
    push_cmd(OP_PUT, CHAR_BACKSPACE, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_PUT, 8'hFF, 11'h7FF);
    push_cmd(OP_PUT, 8'h00, 11'd0);
    push_cmd(OP_PUT, 8'h41, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd1);
    push_cmd(OP_PUT, CHAR_NEWLINE, 11'd0);
    // backspace from column 0 wraps to the end of the row above
    push_cmd(OP_PUT, CHAR_BACKSPACE, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd79);
    push_cmd(OP_PUT, 8'h7E, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd79);
    push_cmd(OP_UNUSED, 8'hFF, 11'h7FF);
    push_cmd(OP_UNUSED, 8'h00, 11'd0);
    push_cmd(OP_CLEAR, 8'hAA, 11'd5);
    push_cmd(OP_READ, 8'h00, 11'd79);
    push_cmd(OP_PUT, 8'h55, 11'h2AA);
    push_cmd(OP_READ, 8'h00, 11'd0);
    drain_console();

    for (int p = 0; p < PHASES; p++) begin
      @(posedge clk);
      attr_we    <= 1'b1;
      attr_wdata <= phase_attr[p];
      text_attr  = phase_attr[p];
      @(posedge clk);
      attr_we <= 1'b0;
      // run one phase without any stalls on either side
      steady = (p == 2);
      for (int i = 0; i < PHASE_CMDS; i++) queued_cmds.push_back(random_console_cmd());
      drain_console();
    end

    if (errors == 0) begin
      $display("text_console_writer_test: PASS");
    end else begin
      $display("text_console_writer_test: FAIL");
    end
    $finish;
  end

endmodule
